// ===== rtl/emav_pkg.sv =====
// Shared widths, constants and word types for the multiturn angle and velocity unit.
`timescale 1ns / 1ps

package emav_pkg;

  localparam int COUNT_BITS = 15;
  localparam int TIME_BITS = 24;
  localparam int TURN_BITS = 16;
  localparam int CPR_BITS = 16;
  localparam int FA_BITS = 32;
  localparam int VEL_BITS = 32;

  localparam int MAX_DT_MS = 500;
  localparam int DT_BITS = $clog2(MAX_DT_MS + 1);
  localparam int CPR_RESET = 4096;

  // Times 1000 is done as times 1024 less times 16 less times 8.
  localparam int SCALE_SHIFT_HI = 10;
  localparam int SCALE_SHIFT_MID = 4;
  localparam int SCALE_SHIFT_LO = 3;

  localparam int CMP_BITS = CPR_BITS + 3;
  localparam int PROD_BITS = FA_BITS + 1 + SCALE_SHIFT_HI;
  localparam int MUL_CNT_BITS = $clog2(CPR_BITS + 1);
  localparam int DIV_CNT_BITS = $clog2(PROD_BITS + 1);

  typedef struct packed {
    logic [COUNT_BITS-1:0] raw_count;
    logic [TIME_BITS-1:0]  time_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [TURN_BITS-1:0] turns;
    logic [COUNT_BITS-1:0]       angle_count;
    logic signed [VEL_BITS-1:0]  velocity;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== rtl/emav_mul.sv =====
// Bit-serial shift-and-add multiplier of the turn count by counts per revolution.
`timescale 1ns / 1ps

module emav_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [emav_pkg::TURN_BITS-1:0] turn,
  input  logic [emav_pkg::CPR_BITS-1:0]       cpr,
  output logic [emav_pkg::FA_BITS-1:0]        product,
  output emav_pkg::unit_stat_t                stat
);
  import emav_pkg::*;

  logic [FA_BITS-1:0]      acc;
  logic [FA_BITS-1:0]      mcand;
  logic [CPR_BITS-1:0]     mplier;
  logic [MUL_CNT_BITS-1:0] cnt;
  logic                    busy;
  logic                    done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= MUL_CNT_BITS'(CPR_BITS);
      end else if (busy) begin
        cnt <= cnt - MUL_CNT_BITS'(1);
        if (cnt == MUL_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= FA_BITS'(turn);
      mplier <= cpr;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign product   = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/emav_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module emav_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [emav_pkg::PROD_BITS-1:0]    dividend,
  input  logic [emav_pkg::DT_BITS-1:0]      divisor,
  output logic [emav_pkg::PROD_BITS-1:0]    quotient,
  output emav_pkg::unit_stat_t              stat
);
  import emav_pkg::*;

  logic [PROD_BITS-1:0]    quo;
  logic [DT_BITS-1:0]      rem;
  logic [DT_BITS-1:0]      dsr;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic                    busy;
  logic                    done;
  logic [DT_BITS:0]        trial;
  logic                    fits;

  assign trial = {rem, quo[PROD_BITS-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_BITS'(PROD_BITS);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_BITS'(1);
        if (cnt == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DT_BITS'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[DT_BITS-1:0];
      end
      quo <= {quo[PROD_BITS-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/encoder_multiturn_angle_velocity_unit.sv =====
// Top level of the multiturn angle unwrap and velocity unit.
// Each input word carries an absolute angle count and a millisecond timestamp; each one gives
// exactly one output word with the turn count, the angle count and the velocity in counts per
// second, truncated toward zero and saturated to 32 bits. The time from acceptance to a ready
// result is set mainly by the serial divider, which retires one of 43 quotient bits per cycle,
// and the serial multiplier, which forms turns times counts per revolution over 16 bits.
// One word is in flight at a time; a finished result waits in the output register while the
// next word is accepted. The first word after reset gives a velocity of zero. The user must
// write counts per revolution only while the unit is idle; the block does not enforce this.
`timescale 1ns / 1ps

module encoder_multiturn_angle_velocity_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [emav_pkg::CPR_BITS-1:0]  cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  emav_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output emav_pkg::out_item_t            out_data
);
  import emav_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOAD = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_SUB  = 4'd3;
  localparam logic [3:0] ST_ABS  = 4'd4;
  localparam logic [3:0] ST_SC1  = 4'd5;
  localparam logic [3:0] ST_SC2  = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  localparam logic [PROD_BITS-1:0] POS_LIM = PROD_BITS'((64'd1 << (VEL_BITS - 1)) - 64'd1);
  localparam logic [PROD_BITS-1:0] NEG_LIM = PROD_BITS'(64'd1 << (VEL_BITS - 1));

  logic [3:0]              state;
  logic [CPR_BITS-1:0]     cpr;
  logic                    primed;
  logic                    first;
  logic [COUNT_BITS-1:0]   last_count;
  logic [TIME_BITS-1:0]    last_time;
  logic [FA_BITS-1:0]      last_fa;
  logic [TURN_BITS-1:0]    turn;
  logic [COUNT_BITS-1:0]   count_r;
  logic [TIME_BITS-1:0]    now_r;
  logic [DT_BITS-1:0]      dt;
  logic [FA_BITS-1:0]      fa_r;
  logic [FA_BITS:0]        delta_r;
  logic [FA_BITS:0]        mag;
  logic                    neg;
  logic [PROD_BITS-1:0]    scaled;
  logic [VEL_BITS-1:0]     vel_r;

  logic [COUNT_BITS:0]     d_w;
  logic [COUNT_BITS-1:0]   d_mag;
  logic [CMP_BITS-1:0]     five_mag;
  logic [CMP_BITS-1:0]     four_cpr;
  logic                    wrap;
  logic [TURN_BITS-1:0]    turn_next;
  logic [TIME_BITS-1:0]    dt_raw;
  logic [DT_BITS-1:0]      dt_next;
  logic [PROD_BITS-1:0]    dividend;
  logic [VEL_BITS-1:0]     vel_next;

  logic                    mul_start;
  logic [FA_BITS-1:0]      product;
  unit_stat_t              mul_stat;
  logic                    div_start;
  logic [PROD_BITS-1:0]    quotient;
  unit_stat_t              div_stat;

  assign d_w      = {1'b0, count_r} - {1'b0, last_count};
  assign d_mag    = d_w[COUNT_BITS] ? COUNT_BITS'(-d_w) : d_w[COUNT_BITS-1:0];
  assign five_mag = (CMP_BITS'(d_mag) << 2) + CMP_BITS'(d_mag);
  assign four_cpr = CMP_BITS'(cpr) << 2;
  assign wrap     = primed && (five_mag > four_cpr);

  always_comb begin
    turn_next = turn;
    if (wrap) begin
      if (d_w[COUNT_BITS]) begin
        turn_next = turn + TURN_BITS'(1);
      end else begin
        turn_next = turn - TURN_BITS'(1);
      end
    end
  end

  assign dt_raw  = now_r - last_time - TIME_BITS'(now_r < last_time);
  assign dt_next = (dt_raw == '0 || dt_raw > TIME_BITS'(MAX_DT_MS)) ? DT_BITS'(1)
                                                                   : dt_raw[DT_BITS-1:0];

  assign dividend = scaled - (PROD_BITS'(mag) << SCALE_SHIFT_LO);

  always_comb begin
    if (first) begin
      vel_next = '0;
    end else if (neg) begin
      vel_next = (quotient > NEG_LIM) ? NEG_LIM[VEL_BITS-1:0] : VEL_BITS'(-quotient);
    end else begin
      vel_next = (quotient > POS_LIM) ? POS_LIM[VEL_BITS-1:0] : quotient[VEL_BITS-1:0];
    end
  end

  assign mul_start = (state == ST_LOAD);
  assign div_start = (state == ST_SC2);
  assign in_ready  = (state == ST_IDLE);

  emav_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .turn    (turn_next),
    .cpr     (cpr),
    .product (product),
    .stat    (mul_stat)
  );

  emav_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (dt),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cpr        <= CPR_BITS'(CPR_RESET);
      primed     <= 1'b0;
      first      <= 1'b0;
      last_count <= '0;
      last_time  <= '0;
      last_fa    <= '0;
      turn       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wen) begin
        cpr <= cfg_wdata;
      end
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          turn       <= turn_next;
          first      <= !primed;
          primed     <= 1'b1;
          last_count <= count_r;
          last_time  <= now_r;
          state      <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_stat.done) begin
            state <= ST_SUB;
          end
        end
        ST_SUB: begin
          last_fa <= fa_r;
          state   <= ST_ABS;
        end
        ST_ABS: begin
          state <= ST_SC1;
        end
        ST_SC1: begin
          state <= ST_SC2;
        end
        ST_SC2: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      count_r <= in_data.raw_count;
      now_r   <= in_data.time_ms;
    end
    if (state == ST_LOAD) begin
      dt <= dt_next;
    end
    if (state == ST_MUL && mul_stat.done) begin
      fa_r <= product + FA_BITS'(count_r);
    end
    if (state == ST_SUB) begin
      delta_r <= {fa_r[FA_BITS-1], fa_r} - {last_fa[FA_BITS-1], last_fa};
    end
    if (state == ST_ABS) begin
      neg <= delta_r[FA_BITS];
      mag <= delta_r[FA_BITS] ? (~delta_r + (FA_BITS + 1)'(1)) : delta_r;
    end
    if (state == ST_SC1) begin
      scaled <= (PROD_BITS'(mag) << SCALE_SHIFT_HI) - (PROD_BITS'(mag) << SCALE_SHIFT_MID);
    end
    if (state == ST_DIV && div_stat.done) begin
      vel_r <= vel_next;
    end
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_data.turns       <= turn;
      out_data.angle_count <= count_r;
      out_data.velocity    <= vel_r;
    end
  end

  a_accept_loads : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_LOAD)
    else $error("accepted word did not start the load step");

  a_idle_units_quiet : assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !mul_stat.busy && !div_stat.busy)
    else $error("arithmetic unit busy while idle");

  a_dt_in_range : assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> dt != '0 && dt <= DT_BITS'(MAX_DT_MS))
    else $error("elapsed time outside one to the limit");

  a_div_to_done : assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && div_stat.done |=> state == ST_DONE && !div_stat.busy)
    else $error("divider finish not followed by result hand-off");

endmodule
